/* design/cirb_pkg.sv */
package cirb_pkg;

    localparam int NODE_COUNT_DEF     = 32;
    localparam int ROUTE_CAPACITY_DEF = 32;

    localparam int FUNC_W = 3;
    localparam int NODE_W = 5;
    localparam int COST_W = 24;
    localparam int TOUR_W = 30;
    localparam int POS_W  = 6;
    // a + b - link, signed
    localparam int DELTA_W = COST_W + 3;

    localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_APPEND = 3'd2;
    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_EMIT   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REF_RD,
        S_REF_WR,
        S_CHECK,
        S_INS_A,
        S_INS_B,
        S_INS_C,
        S_COMMIT,
        S_RESULT,
        S_EMIT
    } t_state;

    // which matrix entry to fetch: previous->next, previous->new, new->next
    typedef enum logic [1:0] {
        RD_LINK,
        RD_PN,
        RD_NQ
    } t_rd;

    typedef struct packed {
        logic accept;
        logic clear;
        logic rd_issue;
        t_rd  rd_kind;
        logic ref_take;
        logic srch_init;
        logic a_take;
        logic b_take;
        logic commit;
        logic out_ins;
        logic out_full;
        logic out_emit;
    } t_cmd;

endpackage

/* design/cirb_ctrl.sv */
module cirb_ctrl
    import cirb_pkg::*;
#(
    parameter int ROUTE_CAPACITY = ROUTE_CAPACITY_DEF,
    parameter int IW             = $clog2(ROUTE_CAPACITY + 2)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [IW-1:0]     i_len,
    output logic              busy,
    output t_cmd              o_cmd,
    output logic [IW-1:0]     o_idx
);

    t_state            r_state, n_state;
    logic [IW-1:0]     r_idx, n_idx;
    logic [FUNC_W-1:0] r_func, n_func;
    logic              accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign o_idx  = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_func  <= FN_WRITE;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_func  <= n_func;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_func  = r_func;
        o_cmd   = '0;
        o_cmd.rd_kind = RD_LINK;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.accept = 1'b1;
                    n_func = i_func;
                    n_idx  = '0;
                    if (i_func == FN_CLEAR) begin
                        o_cmd.clear = 1'b1;
                    end else if (i_func == FN_APPEND || i_func == FN_INSERT
                                 || i_func == FN_EMIT) begin
                        n_state = S_REF_RD;
                    end
                end
            end
            // rebuild the per-edge costs, matrix may have changed since last time
            S_REF_RD: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.rd_kind  = RD_LINK;
                n_state = S_REF_WR;
            end
            S_REF_WR: begin
                o_cmd.ref_take = 1'b1;
                if (r_idx == i_len) begin
                    n_state = S_CHECK;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_REF_RD;
                end
            end
            S_CHECK: begin
                if (r_func == FN_EMIT) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else if (int'(i_len) >= ROUTE_CAPACITY) begin
                    o_cmd.out_full = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    o_cmd.srch_init = 1'b1;
                    n_idx   = (r_func == FN_APPEND) ? i_len : '0;
                    n_state = S_INS_A;
                end
            end
            S_INS_A: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.rd_kind  = RD_PN;
                n_state = S_INS_B;
            end
            S_INS_B: begin
                o_cmd.a_take   = 1'b1;
                o_cmd.rd_issue = 1'b1;
                o_cmd.rd_kind  = RD_NQ;
                n_state = S_INS_C;
            end
            S_INS_C: begin
                o_cmd.b_take = 1'b1;
                if (r_idx == i_len) begin
                    n_state = S_COMMIT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_INS_A;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                o_cmd.out_ins = 1'b1;
                n_state = S_IDLE;
            end
            S_EMIT: begin
                o_cmd.out_emit = 1'b1;
                if (r_idx == i_len + 1'b1) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* design/cirb_datapath.sv */
module cirb_datapath
    import cirb_pkg::*;
#(
    parameter int NODE_COUNT     = NODE_COUNT_DEF,
    parameter int ROUTE_CAPACITY = ROUTE_CAPACITY_DEF,
    parameter int IW             = $clog2(ROUTE_CAPACITY + 2)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [IW-1:0]     i_idx,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [NODE_W-1:0] i_from_node,
    input  logic [NODE_W-1:0] i_to_node,
    input  logic [COST_W-1:0] i_edge_cost,
    input  logic [NODE_W-1:0] i_node,
    output logic [IW-1:0]     o_len,
    output logic              o_valid,
    output logic              o_status,
    output logic [POS_W-1:0]  o_position,
    output logic [TOUR_W-1:0] o_route_cost,
    output logic [NODE_W-1:0] o_node_out,
    output logic              o_last
);

    localparam int DEPTH = NODE_COUNT * NODE_COUNT;
    localparam int AW    = $clog2(DEPTH);

    logic [COST_W-1:0] mem [DEPTH];

    logic [NODE_W-1:0]        r_route [ROUTE_CAPACITY];
    logic [COST_W-1:0]        r_link  [ROUTE_CAPACITY + 1];
    logic [IW-1:0]            r_len;
    logic [TOUR_W-1:0]        r_tour;
    logic [NODE_W-1:0]        r_node;
    logic [COST_W-1:0]        r_rd_data;
    logic                     r_rd_zero;
    logic [COST_W-1:0]        r_a;
    logic [COST_W-1:0]        r_lk;
    logic signed [DELTA_W-1:0] r_best;
    logic [IW-1:0]            r_best_pos;
    logic                     r_have;

    logic [NODE_W-1:0] prev_node, next_node, ra, rb;
    logic [COST_W-1:0] link_k, rd_val;
    logic signed [DELTA_W-1:0] delta;
    logic signed [31:0] tour_sum;

    function automatic logic in_range(logic [NODE_W-1:0] x);
        return int'(x) < NODE_COUNT;
    endfunction

    function automatic logic [AW-1:0] mat_addr(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
        return AW'(int'(a) * NODE_COUNT + int'(b));
    endfunction

    assign o_len  = r_len;
    assign rd_val = r_rd_zero ? '0 : r_rd_data;

    // neighbours of position idx in the closed tour
    always_comb begin
        prev_node = '0;
        next_node = '0;
        link_k    = '0;
        for (int j = 0; j < ROUTE_CAPACITY; j++) begin
            if (i_idx == IW'(j + 1)) prev_node = r_route[j];
            if (i_idx == IW'(j) && i_idx != r_len) next_node = r_route[j];
        end
        for (int j = 0; j <= ROUTE_CAPACITY; j++) begin
            if (i_idx == IW'(j)) link_k = r_link[j];
        end
    end

    always_comb begin
        case (i_cmd.rd_kind)
            RD_PN: begin
                ra = prev_node;
                rb = r_node;
            end
            RD_NQ: begin
                ra = r_node;
                rb = next_node;
            end
            default: begin
                ra = prev_node;
                rb = next_node;
            end
        endcase
    end

    assign delta = signed'(DELTA_W'(r_a)) + signed'(DELTA_W'(rd_val))
                   - signed'(DELTA_W'(r_lk));
    assign tour_sum = signed'({2'b00, r_tour}) + 32'(r_best);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_func == FN_WRITE && in_range(i_from_node)
            && in_range(i_to_node)) begin
            mem[mat_addr(i_from_node, i_to_node)] <= i_edge_cost;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= mem[mat_addr(ra, rb)];
            r_rd_zero <= !(in_range(ra) && in_range(rb));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_have  <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.out_ins || i_cmd.out_full || i_cmd.out_emit;
            if (i_cmd.clear) r_len <= '0;
            if (i_cmd.commit) r_len <= r_len + 1'b1;
            if (i_cmd.srch_init) r_have <= 1'b0;
            if (i_cmd.b_take) r_have <= 1'b1;
        end
    end

    // links are rebuilt at the start of every route command, so a commit leaves them alone
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_node <= i_node;
        if (i_cmd.ref_take) begin
            // empty route costs nothing, so its only link is zero as well
            for (int j = 0; j <= ROUTE_CAPACITY; j++) begin
                if (i_idx == IW'(j)) r_link[j] <= (r_len == '0) ? '0 : rd_val;
            end
            if (r_len == '0 || i_idx == '0) begin
                r_tour <= (r_len == '0) ? '0 : TOUR_W'(rd_val);
            end else begin
                r_tour <= r_tour + TOUR_W'(rd_val);
            end
        end
        if (i_cmd.a_take) begin
            r_a  <= rd_val;
            r_lk <= link_k;
        end
        if (i_cmd.b_take && (!r_have || delta < r_best)) begin
            r_best     <= delta;
            r_best_pos <= i_idx;
        end
        if (i_cmd.commit) begin
            r_tour <= TOUR_W'(tour_sum);
            for (int j = 0; j < ROUTE_CAPACITY; j++) begin
                if (IW'(j) == r_best_pos) r_route[j] <= r_node;
                else if (j > 0 && IW'(j) > r_best_pos) r_route[j] <= r_route[j-1];
            end
        end
        o_status     <= i_cmd.out_full;
        o_position   <= i_cmd.out_ins ? POS_W'(r_best_pos) : '0;
        o_route_cost <= r_tour;
        o_node_out   <= (i_cmd.out_emit && i_idx != r_len + 1'b1) ? prev_node : '0;
        o_last       <= i_cmd.out_ins || i_cmd.out_full
                        || (i_cmd.out_emit && i_idx == r_len + 1'b1);
    end

endmodule

/* design/cheapest_insertion_route_builder_core.sv */
// Cheapest-insertion route builder. Raise start with a command while busy is
// low; results then appear on the o_ ports for single cycles marked by o_valid,
// and the receiver cannot stall them. Every route command (append, insert,
// emit) first rereads the n+1 tour edges of the current route from the cost
// matrix, one edge at a time, as the matrix has a single read port. An insert
// then tries every position with two matrix reads each. An emit gives one
// result per cycle (n+2 results) for a route of n nodes. Matrix entries never
// written read as anything.
module cheapest_insertion_route_builder_core
    import cirb_pkg::*;
#(
    parameter int NODE_COUNT     = NODE_COUNT_DEF,
    parameter int ROUTE_CAPACITY = ROUTE_CAPACITY_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [NODE_W-1:0] i_from_node,
    input  logic [NODE_W-1:0] i_to_node,
    input  logic [COST_W-1:0] i_edge_cost,
    input  logic [NODE_W-1:0] i_node,
    output logic              o_valid,
    output logic              o_status,
    output logic [POS_W-1:0]  o_position,
    output logic [TOUR_W-1:0] o_route_cost,
    output logic [NODE_W-1:0] o_node_out,
    output logic              o_last
);

    localparam int IW = $clog2(ROUTE_CAPACITY + 2);

    t_cmd          cmd;
    logic [IW-1:0] idx;
    logic [IW-1:0] len;

    cirb_ctrl #(
        .ROUTE_CAPACITY(ROUTE_CAPACITY),
        .IW            (IW)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_func (i_func),
        .i_len  (len),
        .busy   (busy),
        .o_cmd  (cmd),
        .o_idx  (idx)
    );

    cirb_datapath #(
        .NODE_COUNT    (NODE_COUNT),
        .ROUTE_CAPACITY(ROUTE_CAPACITY),
        .IW            (IW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_idx       (idx),
        .i_func      (i_func),
        .i_from_node (i_from_node),
        .i_to_node   (i_to_node),
        .i_edge_cost (i_edge_cost),
        .i_node      (i_node),
        .o_len       (len),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_position  (o_position),
        .o_route_cost(o_route_cost),
        .o_node_out  (o_node_out),
        .o_last      (o_last)
    );

endmodule

/* sim/tb_cheapest_insertion_route_builder_core.sv */
`timescale 1ns / 1ps

module tb_cheapest_insertion_route_builder_core;
    import cirb_pkg::*;

    localparam int NODES    = NODE_COUNT_DEF;
    localparam int CAPACITY = ROUTE_CAPACITY_DEF;
    // route nodes are drawn from 0 .. USED-1 only, so the matrix fill stays small
    localparam int USED     = 12;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [TOUR_W-1:0] TOUR_SAT = {TOUR_W{1'b1}};

    typedef struct {
        logic [FUNC_W-1:0] func;
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [COST_W-1:0] edge_cost;
        logic [NODE_W-1:0] node;
        int                gap;
        bit                drain;
    } t_cmd_item;

    typedef struct {
        logic              status;
        logic [POS_W-1:0]  position;
        logic [TOUR_W-1:0] route_cost;
        logic [NODE_W-1:0] node_out;
        logic              last;
    } t_route_res;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [FUNC_W-1:0] i_func = '0;
    logic [NODE_W-1:0] i_from_node = '0;
    logic [NODE_W-1:0] i_to_node = '0;
    logic [COST_W-1:0] i_edge_cost = '0;
    logic [NODE_W-1:0] i_node = '0;
    logic              o_valid;
    logic              o_status;
    logic [POS_W-1:0]  o_position;
    logic [TOUR_W-1:0] o_route_cost;
    logic [NODE_W-1:0] o_node_out;
    logic              o_last;

    cheapest_insertion_route_builder_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_func       (i_func),
        .i_from_node  (i_from_node),
        .i_to_node    (i_to_node),
        .i_edge_cost  (i_edge_cost),
        .i_node       (i_node),
        .o_valid      (o_valid),
        .o_status     (o_status),
        .o_position   (o_position),
        .o_route_cost (o_route_cost),
        .o_node_out   (o_node_out),
        .o_last       (o_last)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [COST_W-1:0] cost_tbl [NODES*NODES];
    logic [NODE_W-1:0] route [CAPACITY];
    int                route_len;

    t_cmd_item  pending_cmds [$];
    t_route_res expected_res [$];
    t_cmd_item  cur;
    int  gap_left;
    int  idle_cycles;
    int  mismatches;
    int  n_accepted, n_results, n_inserts, n_full, n_emits;

    function automatic logic [63:0] tour_sum(input logic [NODE_W-1:0] r [CAPACITY+1],
                                             input int n);
        logic [63:0] sum;
        if (n == 0) return 0;
        sum = cost_tbl[r[0]] + cost_tbl[r[n-1]*NODES];
        for (int i = 0; i + 1 < n; i++)
            sum += cost_tbl[r[i]*NODES + r[i+1]];
        return sum;
    endfunction

    function automatic logic [TOUR_W-1:0] sat(input logic [63:0] c);
        return (c > TOUR_SAT) ? TOUR_SAT : c[TOUR_W-1:0];
    endfunction

    function automatic void push_res(input logic st, input int pos, input logic [63:0] c,
                                     input logic [NODE_W-1:0] nd, input logic lst);
        t_route_res r;
        r.status = st;
        r.position = pos[POS_W-1:0];
        r.route_cost = sat(c);
        r.node_out = nd;
        r.last = lst;
        expected_res = {expected_res, r};
    endfunction

    task automatic predict_route(input t_cmd_item it);
        logic [NODE_W-1:0] cur_r [CAPACITY+1];
        logic [NODE_W-1:0] trial [CAPACITY+1];
        logic [63:0] best, c;
        int best_pos;
        for (int i = 0; i <= CAPACITY; i++) cur_r[i] = (i < CAPACITY) ? route[i] : '0;
        case (it.func)
            FN_WRITE: cost_tbl[it.from_node*NODES + it.to_node] = it.edge_cost;
            FN_CLEAR: route_len = 0;
            FN_APPEND, FN_INSERT: begin
                if (route_len >= CAPACITY) begin
                    n_full++;
                    push_res(1'b1, 0, tour_sum(cur_r, route_len), '0, 1'b1);
                end else begin
                    best_pos = route_len;
                    best = 0;
                    if (it.func == FN_INSERT) begin
                        n_inserts++;
                        for (int k = 0; k <= route_len; k++) begin
                            for (int j = 0; j < k; j++) trial[j] = cur_r[j];
                            trial[k] = it.node;
                            for (int j = k; j < route_len; j++) trial[j+1] = cur_r[j];
                            c = tour_sum(trial, route_len + 1);
                            if (k == 0 || c < best) begin
                                best = c;
                                best_pos = k;
                            end
                        end
                    end
                    for (int j = route_len; j > best_pos; j--) route[j] = route[j-1];
                    route[best_pos] = it.node;
                    route_len++;
                    for (int i = 0; i < CAPACITY; i++) cur_r[i] = route[i];
                    push_res(1'b0, best_pos, tour_sum(cur_r, route_len), '0, 1'b1);
                end
            end
            FN_EMIT: begin
                n_emits++;
                c = tour_sum(cur_r, route_len);
                push_res(1'b0, 0, c, '0, 1'b0);
                for (int i = 0; i < route_len; i++) push_res(1'b0, 0, c, route[i], 1'b0);
                push_res(1'b0, 0, c, '0, 1'b1);
            end
            default: ;
        endcase
    endtask

    function automatic int draw_gap();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
    endfunction

    task automatic add_cmd(input logic [FUNC_W-1:0] f, input int fr, input int to,
                           input int ec, input int nd, input int gap, input bit drain);
        t_cmd_item it;
        it.func = f;
        it.from_node = fr[NODE_W-1:0];
        it.to_node = to[NODE_W-1:0];
        it.edge_cost = ec[COST_W-1:0];
        it.node = nd[NODE_W-1:0];
        it.gap = gap;
        it.drain = drain;
        pending_cmds = {pending_cmds, it};
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                predict_route(cur);
                n_accepted++;
                gap_left = cur.gap;
            end
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_cmds.size() > 0 && !(pending_cmds[0].drain &&
                             (expected_res.size() > 0 || busy))) begin
                    cur = pending_cmds.pop_front();
                    i_func <= cur.func;
                    i_from_node <= cur.from_node;
                    i_to_node <= cur.to_node;
                    i_edge_cost <= cur.edge_cost;
                    i_node <= cur.node;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) begin
                n_results++;
                if (expected_res.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: node %0d cost %0d",
                                 o_node_out, o_route_cost);
                end else begin
                    t_route_res e;
                    e = expected_res.pop_front();
                    if (o_status !== e.status || o_position !== e.position ||
                        o_route_cost !== e.route_cost || o_node_out !== e.node_out ||
                        o_last !== e.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: exp st%0d pos%0d cost%0d node%0d last%0d,",
                                      " got st%0d pos%0d cost%0d node%0d last%0d"},
                                     e.status, e.position, e.route_cost, e.node_out, e.last,
                                     o_status, o_position, o_route_cost, o_node_out, o_last);
                    end
                end
            end
            if (o_valid || (start && !busy)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("tb_cheapest_insertion_route_builder_core: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int f;
        route_len = 0;
        mismatches = 0;
        idle_cycles = 0;
        n_accepted = 0; n_results = 0; n_inserts = 0; n_full = 0; n_emits = 0;

        // every edge among the route nodes written up front, so no route read hits a gap
        for (int a = 0; a < USED; a++)
            for (int b = 0; b < USED; b++)
                add_cmd(FN_WRITE, a, b, $urandom_range(0, 4000), 0, 0, 0);
        // equal costs among depot, 1, 2 and 7 make every insert position tie
        for (int a = 0; a < 4; a++)
            for (int b = 0; b < 4; b++)
                add_cmd(FN_WRITE, (a == 3) ? 7 : a, (b == 3) ? 7 : b, 100, 0, 0, 0);

        // directed
        add_cmd(FN_EMIT, 0, 0, 0, 0, 0, 1);
        add_cmd(FN_APPEND, 0, 0, 0, 1, 3, 0);
        add_cmd(FN_APPEND, 0, 0, 0, 2, 0, 0);
        add_cmd(FN_INSERT, 0, 0, 0, 7, 0, 0);
        add_cmd(FN_EMIT, 0, 0, 0, 0, 0, 0);
        add_cmd(3'd5, 31, 31, 24'hFFFFFF, 31, 0, 0);
        add_cmd(3'd6, 0, 0, 0, 0, 0, 0);
        add_cmd(3'd7, 0, 0, 0, 0, 0, 0);
        add_cmd(FN_WRITE, 0, USED - 1, 24'hFFFFFF, 0, 0, 0);
        add_cmd(FN_WRITE, USED - 1, 0, 24'hFFFFFF, 0, 0, 0);
        add_cmd(FN_WRITE, USED - 1, USED - 1, 24'hFFFFFF, 0, 0, 0);
        add_cmd(FN_INSERT, 0, 0, 0, USED - 1, 0, 0);
        add_cmd(FN_INSERT, 0, 0, 0, 0, 0, 0);
        add_cmd(FN_CLEAR, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < CAPACITY; i++) add_cmd(FN_APPEND, 0, 0, 0, USED - 1, 0, 0);
        add_cmd(FN_APPEND, 0, 0, 0, 5, 0, 0);
        add_cmd(FN_INSERT, 0, 0, 0, 5, 0, 0);
        add_cmd(FN_EMIT, 0, 0, 0, 0, 0, 0);
        add_cmd(FN_CLEAR, 0, 0, 0, 0, 0, 1);

        // random
        for (int i = 0; i < 200; i++) begin
            f = $urandom_range(0, 99);
            add_cmd(f < 15 ? FN_WRITE : f < 19 ? FN_CLEAR : f < 42 ? FN_APPEND :
                    f < 80 ? FN_INSERT : f < 95 ? FN_EMIT : 3'($urandom_range(5, 7)),
                    $urandom_range(0, 31), $urandom_range(0, 31),
                    ($urandom_range(0, 7) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                : $urandom_range(0, 20000),
                    $urandom_range(0, USED - 1),
                    (i % 60 < 10) ? 0 : draw_gap(), (i % 97 == 50));
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_cmds.size() == 0 && !start);
        wait (expected_res.size() == 0);
        repeat (300) @(posedge i_clk);
        $display("%0d commands transferred, %0d results checked", n_accepted, n_results);
        $display("covered %0d inserts, %0d emits, %0d full-route rejects",
                 n_inserts, n_emits, n_full);
        if (mismatches == 0 && expected_res.size() == 0) begin
            $display("tb_cheapest_insertion_route_builder_core: PASS");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches, expected_res.size());
            $display("tb_cheapest_insertion_route_builder_core: FAIL");
        end
        $finish;
    end

endmodule
